>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the descriptor parser files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/edp_pkg.sv
package edp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ES_TAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_TAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SI_TAG = 2'd2;

  localparam logic [7:0] ES_TAG_RST = 8'd3;
  localparam logic [7:0] DC_TAG_RST = 8'd4;
  localparam logic [7:0] SI_TAG_RST = 8'd5;

  // Result status codes
  localparam int unsigned ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER = 2'd2;
  localparam logic [ST_W-1:0] ST_RSVD = 2'd3;

  // Descriptor byte masks
  localparam logic [7:0] LEN_MASK = 8'h7f;
  localparam int unsigned LEN_MORE_BIT = 7;
  localparam int unsigned DC_FIXED_BYTES = 13;

  // Stream word layout
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OT_LSB   = ST_W;
  localparam int unsigned IOFF_LSB = OT_LSB + 8;
  localparam int unsigned ILEN_LSB = IOFF_LSB + 8;
  localparam int unsigned PAD_LSB  = ILEN_LSB + 9;

  // Byte count field wide enough for the largest buffer (4096 bytes)
  localparam int unsigned CNT_W = 13;

  typedef struct packed {
    logic             bank;
    logic             ovf;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } free_t;

endpackage

>>> rtl/core/edp_ram.sv
module edp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/edp_loader.sv
`include "assert_macros.svh"

module edp_loader #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  input  logic [7:0]                            s_tdata_i,
  input  logic                                  s_tlast_i,
  output logic                                  wr_en_o,
  output logic [$clog2(BUFFER_BYTES):0]         wr_addr_o,
  output logic [7:0]                            wr_data_o,
  output logic                                  push_o,
  output edp_pkg::job_t                         job_o,
  input  edp_pkg::free_t                        free_i
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          bank_q;
  logic [1:0]    busy_q, busy_d;
  logic          accept;
  logic          room;

  assign s_tready_o = !busy_q[bank_q];
  assign accept     = s_tvalid_i && s_tready_o;
  assign room       = count_q < CW'(BUFFER_BYTES);

  assign wr_en_o   = accept && room;
  assign wr_addr_o = {bank_q, count_q[AW-1:0]};
  assign wr_data_o = s_tdata_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign push_o      = accept && s_tlast_i;
  assign job_o.bank  = bank_q;
  assign job_o.ovf   = ovf_d;
  assign job_o.count = edp_pkg::CNT_W'(count_d);

  always_comb begin
    busy_d = busy_q;
    if (free_i.valid) begin
      busy_d[free_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (push_o) begin
        // close the atom: start the next one empty in the other bank
        count_q <= '0;
        ovf_q   <= 1'b0;
        bank_q  <= !bank_q;
      end else begin
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  `ASSERT_RST(a_free_busy_bank, clk_i, rst_ni, free_i.valid |-> busy_q[free_i.bank], "bank freed while not in use")

endmodule

>>> rtl/core/edp_job_queue.sv
`include "assert_macros.svh"

module edp_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  edp_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output edp_pkg::job_t job_o
);

  edp_pkg::job_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;

  assign valid_o = fill_q != 2'd0;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  `ASSERT_RST(a_no_push_full, clk_i, rst_ni, push_i |-> (fill_q != 2'd2) || pop_i, "job pushed into a full queue")
  `ASSERT_ALWAYS(a_no_pop_empty, clk_i, pop_i |-> fill_q != 2'd0, "job popped from an empty queue")

endmodule

>>> rtl/core/edp_parser.sv
`include "assert_macros.svh"

module edp_parser #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [edp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [7:0]                            cfg_data_i,
  input  logic                                  job_valid_i,
  input  edp_pkg::job_t                         job_i,
  output logic                                  job_pop_o,
  output logic                                  rd_en_o,
  output logic [$clog2(BUFFER_BYTES):0]         rd_addr_o,
  input  logic [7:0]                            rd_data_i,
  output edp_pkg::free_t                        free_o,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [edp_pkg::OUT_TDATA_W-1:0]       m_tdata_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES + 2);
  localparam int unsigned VW = (LW > 9) ? LW : 9;

  typedef enum logic [3:0] {
    S_IDLE, S_HTAG, S_HLEN, S_HCHK, S_FLAGS, S_DEP, S_URL,
    S_OCR_A, S_OCR_B, S_OT, S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    HK_ES, HK_DC, HK_SI
  } hdr_kind_e;

  state_e    state_q;
  hdr_kind_e kind_q;
  logic      bank_q;
  logic      rd_wait_q;
  logic [VW-1:0] pos_q, rem_q, len_q;
  logic [7:0]    tag_q;
  logic [2:0]    flags_q;   // dependence, URL, OCR
  logic          here_q;
  logic [edp_pkg::ST_W-1:0] status_q;
  logic [7:0]    ot_q;
  logic [VW-1:0] ioff_q, ilen_q;
  logic [7:0]    es_tag_q, dc_tag_q, si_tag_q;
  logic          m_valid_q;
  logic [edp_pkg::OUT_TDATA_W-1:0] m_data_q;

  logic [VW-1:0]   rd_off;
  logic [VW+6:0]   len_acc;
  logic [VW-1:0]   len_sat;
  logic [VW-1:0]   ulen;
  logic            ocr_skip;
  logic            out_free;
  logic            ok_res;
  logic [7:0]      ioff_clip;
  logic [8:0]      ilen_clip;
  logic [edp_pkg::OUT_TDATA_W-1:0] res_word;

  assign rd_off = ((state_q == S_FLAGS) || (state_q == S_OCR_B)) ? pos_q + VW'(2) : pos_q;
  assign rd_addr_o = {bank_q, rd_off[AW-1:0]};

  always_comb begin
    rd_en_o = 1'b0;
    if (!rd_wait_q) begin
      unique case (state_q)
        S_HTAG, S_HLEN: rd_en_o = rem_q != '0;
        S_FLAGS:        rd_en_o = rem_q >= VW'(3);
        S_OT:           rd_en_o = rem_q >= VW'(edp_pkg::DC_FIXED_BYTES);
        S_URL:          rd_en_o = flags_q[1] && (rem_q != '0);
        S_OCR_A:        rd_en_o = flags_q[0] && (rem_q != '0);
        S_OCR_B:        rd_en_o = rem_q > VW'(2);
        default:        rd_en_o = 1'b0;
      endcase
    end
  end

  // length groups: seven bits each, saturate just above the buffer size
  assign len_acc = {len_q, 7'b0} | (VW + 7)'(rd_data_i & edp_pkg::LEN_MASK);
  assign len_sat = (len_acc > (VW + 7)'(BUFFER_BYTES)) ? VW'(BUFFER_BYTES + 1)
                                                      : len_acc[VW-1:0];
  assign ulen = VW'(rd_data_i) + VW'(1);
  assign ocr_skip = !(here_q && !((rem_q > VW'(2)) && (rd_data_i == dc_tag_q)));

  assign out_free  = !m_valid_q || m_tready_i;
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign free_o.valid = (state_q == S_RESULT) && out_free;
  assign free_o.bank  = bank_q;

  assign ok_res    = status_q == edp_pkg::ST_OK;
  assign ioff_clip = (ioff_q > VW'(255)) ? 8'd255 : ioff_q[7:0];
  assign ilen_clip = (ilen_q > VW'(511)) ? 9'd511 : ilen_q[8:0];

  // result word: everything but the status stays zero unless the parse passed
  always_comb begin
    res_word = '0;
    res_word[edp_pkg::OT_LSB-1:0] = status_q;
    if (ok_res) begin
      res_word[edp_pkg::IOFF_LSB-1:edp_pkg::OT_LSB]   = ot_q;
      res_word[edp_pkg::ILEN_LSB-1:edp_pkg::IOFF_LSB] = ioff_clip;
      res_word[edp_pkg::PAD_LSB-1:edp_pkg::ILEN_LSB]  = ilen_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_wait_q <= 1'b0;
      m_valid_q <= 1'b0;
      es_tag_q  <= edp_pkg::ES_TAG_RST;
      dc_tag_q  <= edp_pkg::DC_TAG_RST;
      si_tag_q  <= edp_pkg::SI_TAG_RST;
    end else begin
      if (free_o.valid) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          edp_pkg::CFG_ES_TAG: es_tag_q <= cfg_data_i;
          edp_pkg::CFG_DC_TAG: dc_tag_q <= cfg_data_i;
          edp_pkg::CFG_SI_TAG: si_tag_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rd_en_o) begin
        rd_wait_q <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            bank_q   <= job_i.bank;
            pos_q    <= '0;
            rem_q    <= VW'(job_i.count);
            kind_q   <= HK_ES;
            ot_q     <= '0;
            ioff_q   <= '0;
            ilen_q   <= '0;
            if (job_i.ovf) begin
              status_q <= edp_pkg::ST_OVER;
              state_q  <= S_RESULT;
            end else begin
              status_q <= edp_pkg::ST_OK;
              state_q  <= S_HTAG;
            end
          end
        end
        S_HTAG: begin
          if (rem_q == '0) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            tag_q     <= rd_data_i;
            pos_q     <= pos_q + VW'(1);
            rem_q     <= rem_q - VW'(1);
            len_q     <= '0;
            state_q   <= S_HLEN;
          end
        end
        S_HLEN: begin
          if (rem_q == '0) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            pos_q     <= pos_q + VW'(1);
            rem_q     <= rem_q - VW'(1);
            len_q     <= len_sat;
            if (!rd_data_i[edp_pkg::LEN_MORE_BIT]) begin
              state_q <= S_HCHK;
            end
          end
        end
        S_HCHK: begin
          if (len_q > rem_q) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else begin
            unique case (kind_q)
              HK_ES: begin
                rem_q <= len_q;
                if (tag_q == es_tag_q) begin
                  state_q <= S_FLAGS;
                end else begin
                  status_q <= edp_pkg::ST_BAD;
                  state_q  <= S_RESULT;
                end
              end
              HK_DC: begin
                rem_q <= len_q;
                if (tag_q == dc_tag_q) begin
                  state_q <= S_OT;
                end else begin
                  status_q <= edp_pkg::ST_BAD;
                  state_q  <= S_RESULT;
                end
              end
              default: begin
                ioff_q  <= pos_q;
                ilen_q  <= len_q;
                state_q <= S_RESULT;
                if (tag_q != si_tag_q) begin
                  status_q <= edp_pkg::ST_BAD;
                end
              end
            endcase
          end
        end
        S_FLAGS: begin
          // skip the ES_ID, read the flags byte
          if (rem_q < VW'(3)) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            flags_q   <= rd_data_i[7:5];
            pos_q     <= pos_q + VW'(3);
            rem_q     <= rem_q - VW'(3);
            state_q   <= S_DEP;
          end
        end
        S_DEP: begin
          if (flags_q[2]) begin
            if (rem_q < VW'(2)) begin
              status_q <= edp_pkg::ST_BAD;
              state_q  <= S_RESULT;
            end else begin
              pos_q   <= pos_q + VW'(2);
              rem_q   <= rem_q - VW'(2);
              state_q <= S_URL;
            end
          end else begin
            state_q <= S_URL;
          end
        end
        S_URL: begin
          if (!flags_q[1]) begin
            state_q <= S_OCR_A;
          end else if (rem_q == '0) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            if (ulen > rem_q) begin
              status_q <= edp_pkg::ST_BAD;
              state_q  <= S_RESULT;
            end else begin
              pos_q   <= pos_q + ulen;
              rem_q   <= rem_q - ulen;
              state_q <= S_OCR_A;
            end
          end
        end
        S_OCR_A: begin
          if (!flags_q[0]) begin
            kind_q  <= HK_DC;
            state_q <= S_HTAG;
          end else if (rem_q == '0) begin
            here_q  <= 1'b0;
            state_q <= S_OCR_B;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            here_q    <= rd_data_i == dc_tag_q;
            state_q   <= S_OCR_B;
          end
        end
        S_OCR_B: begin
          // decide whether the OCR id is present once the later byte is in
          if ((rem_q <= VW'(2)) || rd_wait_q) begin
            rd_wait_q <= 1'b0;
            kind_q    <= HK_DC;
            if (!ocr_skip) begin
              state_q <= S_HTAG;
            end else if (rem_q < VW'(2)) begin
              status_q <= edp_pkg::ST_BAD;
              state_q  <= S_RESULT;
            end else begin
              pos_q   <= pos_q + VW'(2);
              rem_q   <= rem_q - VW'(2);
              state_q <= S_HTAG;
            end
          end
        end
        S_OT: begin
          if (rem_q < VW'(edp_pkg::DC_FIXED_BYTES)) begin
            status_q <= edp_pkg::ST_BAD;
            state_q  <= S_RESULT;
          end else if (rd_wait_q) begin
            rd_wait_q <= 1'b0;
            ot_q      <= rd_data_i;
            pos_q     <= pos_q + VW'(edp_pkg::DC_FIXED_BYTES);
            rem_q     <= rem_q - VW'(edp_pkg::DC_FIXED_BYTES);
            kind_q    <= HK_SI;
            if (rem_q == VW'(edp_pkg::DC_FIXED_BYTES)) begin
              state_q <= S_RESULT;
            end else begin
              state_q <= S_HTAG;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            m_data_q <= res_word;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  `ASSERT_RST(a_status_legal, clk_i, rst_ni, m_valid_q |-> m_data_q[edp_pkg::ST_W-1:0] != edp_pkg::ST_RSVD, "reserved status code on output")
  `ASSERT_RST(a_fail_zero, clk_i, rst_ni, (m_valid_q && (m_data_q[edp_pkg::ST_W-1:0] != edp_pkg::ST_OK)) |-> m_data_q[edp_pkg::OUT_TDATA_W-1:edp_pkg::OT_LSB] == '0, "failed result carries data")
  `ASSERT_RST(a_result_frees, clk_i, rst_ni, free_o.valid |=> m_valid_q, "bank freed without a result")

endmodule

>>> rtl/core/es_descriptor_parser.sv
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   one atom byte per word, tlast on the final byte
// m_axis    out  m_axis_tvalid/m_axis_tready   one parse result per atom
// cfg       in   cfg_we_i (no back-pressure)   es_tag, decoder_config_tag, specific_info_tag
//
// Bytes load at one word per cycle into one of two buffer banks; the word
// with tlast closes the atom and queues it for parsing while loading
// carries on in the other bank. The parser reads the bytes it needs one at
// a time (single read port, registered read), with no new read until the
// previous byte is in; a result waits while the result register is full.
// Input stalls while the bank to load next still holds an atom whose result
// has not yet entered the result register; that register holds a finished
// word while the parser starts on the next atom.
// Reset clears control state and restores the tag registers; the buffer
// is not cleared and needs no clearing pass.
module es_descriptor_parser #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [edp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [7:0]                            cfg_data_i,
  // atom bytes
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [edp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [7:0] data_byte
  input  logic                                  s_axis_tlast,  // last_byte
  // results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [1:0] status, [9:2] object_type, [17:10] info_offset,
  // [26:18] info_length, [31:27] zero
  output logic [edp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int unsigned AW        = $clog2(BUFFER_BYTES);
  localparam int unsigned RAM_DEPTH = 2 * (2 ** AW);

  logic           wr_en;
  logic [AW:0]    wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW:0]    rd_addr;
  logic [7:0]     rd_data;
  logic           push;
  edp_pkg::job_t  push_job;
  logic           pop;
  logic           job_valid;
  edp_pkg::job_t  job;
  edp_pkg::free_t free;

  // front: store bytes, close atoms into jobs
  edp_loader #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_loader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .job_o      (push_job),
    .free_i     (free)
  );

  // two banks of atom bytes, bank select in the top address bit
  edp_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // hold closed atoms until the parser takes them
  edp_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job)
  );

  // back: walk the stored atom and emit the result word
  edp_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .free_o      (free),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned BUF_BYTES    = 256;
  // Stimulus volume and timing knobs
  localparam int unsigned RANDOM_WORDS = 100;
  localparam int unsigned MIN_ATOMS    = 3;
  localparam int unsigned HOLD_CYCLES  = 400;   // long sink hold-off
  localparam int unsigned TAIL_CYCLES  = 100;   // parse latency margin after the last result
  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no word moving on either side
  localparam int unsigned MAX_REPORTS  = 10;

  // ES descriptor flag bits
  localparam logic [7:0] FLAG_DEPENDS = 8'h80;
  localparam logic [7:0] FLAG_URL     = 8'h40;
  localparam logic [7:0] FLAG_OCR     = 8'h20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [edp_pkg::ST_W-1:0] status;
    logic [7:0]               obj_type;
    logic [7:0]               info_off;
    logic [8:0]               info_len;
  } esds_result_t;

  // ---------------------------------------------------------------------------
  // Block ports
  // ---------------------------------------------------------------------------
  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [edp_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = edp_pkg::CFG_ES_TAG;
  logic [7:0]                      cfg_data_i    = 8'h00;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [edp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic                            s_axis_tlast  = 1'b0; // last_byte
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [1:0] status, [9:2] object_type, [17:10] info_offset, [26:18] info_length
  logic [edp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  es_descriptor_parser #(
    .BUFFER_BYTES(BUF_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the atom buffer and the tag registers
  // ---------------------------------------------------------------------------
  logic [7:0]   atom_bytes [BUF_BYTES];
  int unsigned  atom_fill    = 0;
  bit           atom_spilled = 1'b0;
  logic [7:0]   tag_es = edp_pkg::ES_TAG_RST;
  logic [7:0]   tag_dc = edp_pkg::DC_TAG_RST;
  logic [7:0]   tag_si = edp_pkg::SI_TAG_RST;

  esds_result_t results_due[$];   // parse results still owed by the block

  int unsigned words_sent   = 0;
  int unsigned atoms_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned status_tally [4] = '{default: 0};
  int unsigned quiet_cycles = 0;

  // Sink hold-off requests: bump holds_asked, the sink process catches up
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned rx_left     = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Never look past the bytes stored for the current atom.
  function automatic logic [7:0] stored_byte(input int unsigned idx);
    if (idx >= atom_fill) return 8'h00;
    return atom_bytes[idx];
  endfunction

  // Tag plus a length in 7-bit groups; the top bit of a group means more follow.
  function automatic bit take_header(input int unsigned pos, input int unsigned rem,
                                     output logic [7:0] tag, output int unsigned body_pos,
                                     output int unsigned body_len);
    int unsigned len;
    logic [7:0]  x;
    len      = 0;
    tag      = '0;
    body_pos = 0;
    body_len = 0;
    if (rem == 0) return 1'b0;
    tag = stored_byte(pos);
    pos++;
    rem--;
    do begin
      if (rem == 0) return 1'b0;
      x = stored_byte(pos);
      pos++;
      rem--;
      len = (len << 7) | 32'(x & edp_pkg::LEN_MASK);
      // saturate just above the buffer so a huge length is always too large
      if (len > BUF_BYTES) len = BUF_BYTES + 1;
    end while (x[edp_pkg::LEN_MORE_BIT]);
    if (len > rem) return 1'b0;
    body_pos = pos;
    body_len = len;
    return 1'b1;
  endfunction

  function automatic bit walk_decoder_config(input int unsigned pos, input int unsigned rem,
                                             output logic [7:0] obj, output int unsigned ioff,
                                             output int unsigned ilen);
    logic [7:0]  tag;
    int unsigned bpos, blen;
    obj  = '0;
    ioff = 0;
    ilen = 0;
    if (rem < edp_pkg::DC_FIXED_BYTES) return 1'b0;
    obj = stored_byte(pos);
    pos += edp_pkg::DC_FIXED_BYTES;
    rem -= edp_pkg::DC_FIXED_BYTES;
    if (rem == 0) return 1'b1;   // no specific info
    if (!take_header(pos, rem, tag, bpos, blen)) return 1'b0;
    if (tag != tag_si) return 1'b0;
    ioff = bpos;
    ilen = blen;
    return 1'b1;
  endfunction

  function automatic bit walk_es_body(input int unsigned pos, input int unsigned rem,
                                      output logic [7:0] obj, output int unsigned ioff,
                                      output int unsigned ilen);
    logic [7:0]  flags, tag;
    int unsigned ulen, bpos, blen;
    bit          here, later;
    obj  = '0;
    ioff = 0;
    ilen = 0;
    if (rem < 3) return 1'b0;
    pos += 2;   // skip ES_ID
    rem -= 2;
    flags = stored_byte(pos);
    pos++;
    rem--;
    if ((flags & FLAG_DEPENDS) != 0) begin
      if (rem < 2) return 1'b0;
      pos += 2;
      rem -= 2;
    end
    if ((flags & FLAG_URL) != 0) begin
      if (rem == 0) return 1'b0;
      ulen = 32'(stored_byte(pos)) + 1;
      if (ulen > rem) return 1'b0;
      pos += ulen;
      rem -= ulen;
    end
    if ((flags & FLAG_OCR) != 0) begin
      // Treat the OCR id as missing when the decoder config tag comes next and
      // does not also sit two bytes further on.
      here  = rem > 0 && stored_byte(pos) == tag_dc;
      later = rem > 2 && stored_byte(pos + 2) == tag_dc;
      if (!(here && !later)) begin
        if (rem < 2) return 1'b0;
        pos += 2;
        rem -= 2;
      end
    end
    if (!take_header(pos, rem, tag, bpos, blen)) return 1'b0;
    if (tag != tag_dc) return 1'b0;
    return walk_decoder_config(bpos, blen, obj, ioff, ilen);
  endfunction

  function automatic esds_result_t predict_esds_result();
    esds_result_t r;
    logic [7:0]   tag, obj;
    int unsigned  bpos, blen, ioff, ilen;
    r = '0;
    if (atom_spilled) begin
      r.status = edp_pkg::ST_OVER;
    end else if (take_header(0, atom_fill, tag, bpos, blen) && tag == tag_es &&
                 walk_es_body(bpos, blen, obj, ioff, ilen)) begin
      r.status   = edp_pkg::ST_OK;
      r.obj_type = obj;
      r.info_off = 8'((ioff > 255) ? 255 : ioff);
      r.info_len = 9'((ilen > 511) ? 511 : ilen);
    end else begin
      r.status = edp_pkg::ST_BAD;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Atom construction
  // ---------------------------------------------------------------------------
  // Length field, most significant group first, with optional 0x80 padding groups.
  function automatic byte_q_t len_field(input int unsigned n, input int unsigned pad);
    byte_q_t f;
    f.push_front({1'b0, n[6:0]});
    n = n >> 7;
    while (n != 0) begin
      f.push_front({1'b1, n[6:0]});
      n = n >> 7;
    end
    repeat (pad) f.push_front({1'b1, 7'd0});
    return f;
  endfunction

  // Well-formed atom under the current tags; info_bytes < 0 leaves out the specific info.
  function automatic byte_q_t build_esds(input logic [7:0] flags, input int unsigned url_len,
                                         input bit ocr_id, input int info_bytes,
                                         input int unsigned pad);
    byte_q_t dc, es, atom;
    repeat (edp_pkg::DC_FIXED_BYTES) dc.push_back(8'($urandom));   // object type first
    if (info_bytes >= 0) begin
      dc.push_back(tag_si);
      dc = {dc, len_field(info_bytes, pad)};
      repeat (info_bytes) dc.push_back(8'($urandom));
    end
    repeat (2) es.push_back(8'($urandom));   // ES_ID
    es.push_back(flags);
    if ((flags & FLAG_DEPENDS) != 0) repeat (2) es.push_back(8'($urandom));
    if ((flags & FLAG_URL) != 0) begin
      es.push_back(8'(url_len));
      repeat (url_len) es.push_back(8'($urandom));
    end
    if ((flags & FLAG_OCR) != 0 && ocr_id) repeat (2) es.push_back(8'($urandom));
    es.push_back(tag_dc);
    es = {es, len_field(dc.size(), pad), dc};
    atom.push_back(tag_es);
    atom = {atom, len_field(es.size(), pad), es};
    return atom;
  endfunction

  // Mostly well-formed atoms with random content, some damaged, a few pure noise.
  function automatic byte_q_t random_esds();
    byte_q_t     a;
    int unsigned pick, k;
    int          info;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 40)) a.push_back(8'($urandom));
      return a;
    end
    if ($urandom_range(0, 3) == 0) info = -1;
    else if ($urandom_range(0, 9) == 0) info = int'($urandom_range(41, 150));
    else info = int'($urandom_range(0, 12));
    a = build_esds(8'($urandom), $urandom_range(0, 8), $urandom_range(0, 3) != 0, info,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
    if (pick >= 80) begin
      k = $urandom_range(0, a.size() - 1);
      case ($urandom_range(0, 3))
        0: a[k] = a[k] ^ (8'h01 << $urandom_range(0, 7));
        1: a = a[0:$urandom_range(0, a.size() - 2)];
        2: repeat ($urandom_range(1, 6)) a.push_back(8'($urandom));
        default: a[k] = 8'($urandom);
      endcase
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, idle gaps, sink
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sink: alternate ready runs and stalls; serve a long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_left       <= 0;
      holds_done    <= 0;
    end else if (holds_done != holds_asked) begin
      holds_done    <= holds_asked;
      m_axis_tready <= 1'b0;
      rx_left       <= HOLD_CYCLES;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
      // an occasional long run gives stretches with no stalls at all
      rx_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(0, 20);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left       <= idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch in result %0d: expected 0x%0h, got 0x%0h",
               $time, what, results_seen, want, got);
  endtask

  always @(posedge clk_i) begin
    esds_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected word", 0, m_axis_tdata);
      end else begin
        want = results_due.pop_front();
        status_tally[want.status]++;
        if (m_axis_tdata[edp_pkg::OT_LSB-1:0] !== want.status)
          flag_mismatch("status", want.status, m_axis_tdata[edp_pkg::OT_LSB-1:0]);
        if (m_axis_tdata[edp_pkg::IOFF_LSB-1:edp_pkg::OT_LSB] !== want.obj_type)
          flag_mismatch("object_type", want.obj_type,
                        m_axis_tdata[edp_pkg::IOFF_LSB-1:edp_pkg::OT_LSB]);
        if (m_axis_tdata[edp_pkg::ILEN_LSB-1:edp_pkg::IOFF_LSB] !== want.info_off)
          flag_mismatch("info_offset", want.info_off,
                        m_axis_tdata[edp_pkg::ILEN_LSB-1:edp_pkg::IOFF_LSB]);
        if (m_axis_tdata[edp_pkg::PAD_LSB-1:edp_pkg::ILEN_LSB] !== want.info_len)
          flag_mismatch("info_length", want.info_len,
                        m_axis_tdata[edp_pkg::PAD_LSB-1:edp_pkg::ILEN_LSB]);
        if (m_axis_tdata[edp_pkg::OUT_TDATA_W-1:edp_pkg::PAD_LSB] !== '0)
          flag_mismatch("padding", 0, m_axis_tdata[edp_pkg::OUT_TDATA_W-1:edp_pkg::PAD_LSB]);
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // Offer one word, hold it until taken, then store it in the predictor buffer.
  task automatic send_word(input logic [7:0] b, input logic last, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (atom_fill < BUF_BYTES) begin
      atom_bytes[atom_fill] = b;
      atom_fill++;
    end else begin
      atom_spilled = 1'b1;   // buffer full: drop the byte
    end
    if (last) begin
      results_due.push_back(predict_esds_result());
      atom_fill    = 0;
      atom_spilled = 1'b0;
      atoms_sent++;
    end
  endtask

  task automatic send_atom(input byte_q_t atom, input bit steady = 1'b0);
    foreach (atom[i]) send_word(atom[i], i == atom.size() - 1, steady);
  endtask

  // Drop valid and wait until every owed result is in, plus the parse tail.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write all three tag registers on consecutive edges; call only when idle.
  task automatic write_tags(input logic [7:0] es, input logic [7:0] dc,
                            input logic [7:0] si);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= edp_pkg::CFG_ES_TAG;
    cfg_data_i <= es;
    @(posedge clk_i);
    cfg_idx_i  <= edp_pkg::CFG_DC_TAG;
    cfg_data_i <= dc;
    @(posedge clk_i);
    cfg_idx_i  <= edp_pkg::CFG_SI_TAG;
    cfg_data_i <= si;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    tag_es = es;
    tag_dc = dc;
    tag_si = si;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Tiny atoms and the plainest valid one, under the reset tags.
  task automatic test_short_atoms();
    send_atom('{8'hFF});                  // lone tag byte, no length
    send_atom('{8'h00, 8'hFF});           // length never ends
    send_atom('{tag_es, 8'h00});          // empty ES body
    send_atom(build_esds(8'h00, 0, 1'b0, -1, 0));
  endtask

  // Dependence, URL and OCR handling, including skips that run off the end.
  task automatic test_flag_paths();
    send_atom(build_esds(FLAG_DEPENDS | FLAG_URL | FLAG_OCR, 3, 1'b1, 4, 0));
    send_atom(build_esds(8'hFF, 0, 1'b1, 0, 0));          // every flag bit, empty info
    send_atom(build_esds(FLAG_OCR, 0, 1'b0, 2, 0));        // OCR id left out
    send_atom(build_esds(FLAG_URL | FLAG_OCR, 5, 1'b0, -1, 0));
    send_atom('{tag_es, 8'h04, 8'h00, 8'h01, FLAG_DEPENDS, 8'h00});
    send_atom('{tag_es, 8'h04, 8'h00, 8'h01, FLAG_URL, 8'h10});
    send_atom('{tag_es, 8'h04, 8'h00, 8'h01, FLAG_OCR, 8'h00});
  endtask

  // Saturating and padded lengths, lengths one past the end, short decoder config.
  task automatic test_length_limits();
    byte_q_t a;
    send_atom('{tag_es, 8'hFF, 8'hFF, 8'h7F, 8'h00});
    send_atom(build_esds(8'h00, 0, 1'b0, 5, 3));
    a = build_esds(8'h00, 0, 1'b0, 1, 0);
    a[1] = a[1] + 8'd1;                   // outer length one byte too long
    send_atom(a);
    a = build_esds(8'h00, 0, 1'b0, 6, 0);
    void'(a.pop_back());                  // specific info cut short
    send_atom(a);
    a = '{tag_es, 8'd17, 8'h00, 8'h00, 8'h00, tag_dc, 8'd12};
    repeat (12) a.push_back(8'h00);       // decoder config under 13 bytes
    send_atom(a);
  endtask

  // Exactly full buffer, then one byte over, then a normal atom.
  task automatic test_buffer_overflow();
    byte_q_t a;
    a = build_esds(8'h00, 0, 1'b0, 231, 0);   // 256 bytes
    send_atom(a);
    a.push_back(8'($urandom));
    send_atom(a);
    send_atom(build_esds(8'h00, 0, 1'b0, 3, 0));
  endtask

  // Tag registers at their extremes and random values, and atoms that miss a tag.
  task automatic test_tag_registers();
    byte_q_t held_si, held_dc, held_es;
    drain_results();
    write_tags(8'h00, 8'h00, 8'h00);
    repeat (3) send_atom(random_esds());
    drain_results();
    write_tags(8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_atom(random_esds());
    drain_results();
    write_tags(8'($urandom), 8'($urandom), 8'($urandom));
    repeat (3) send_atom(random_esds());
    // build under the current tags, then move one tag away before sending
    held_si = build_esds(8'h00, 0, 1'b0, 3, 0);
    held_dc = build_esds(8'h00, 0, 1'b0, -1, 0);
    held_es = build_esds(8'h00, 0, 1'b0, -1, 0);
    drain_results();
    write_tags(tag_es, tag_dc, tag_si + 8'd1);
    send_atom(held_si);
    drain_results();
    write_tags(tag_es, tag_dc + 8'd1, tag_si);
    send_atom(held_dc);
    drain_results();
    write_tags(tag_es + 8'd1, tag_dc, tag_si);
    send_atom(held_es);
    drain_results();
    write_tags(edp_pkg::ES_TAG_RST, edp_pkg::DC_TAG_RST, edp_pkg::SI_TAG_RST);
  endtask

  task automatic test_random_atoms();
    int unsigned words0, atoms0;
    words0 = words_sent;
    atoms0 = atoms_sent;
    while (words_sent - words0 < RANDOM_WORDS || atoms_sent - atoms0 < MIN_ATOMS)
      send_atom(random_esds(), $urandom_range(0, 5) == 0);
  endtask

  // Hold the sink off while atoms keep coming, so both banks fill and input stalls.
  task automatic test_backpressure();
    drain_results();
    holds_asked <= holds_asked + 1;
    repeat (6) send_atom(random_esds(), 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_atoms();
    test_flag_paths();
    test_length_limits();
    test_buffer_overflow();
    test_tag_registers();
    test_random_atoms();
    test_backpressure();
    drain_results();

    $display("Sent %0d bytes in %0d atoms; checked %0d results (ok %0d, malformed %0d, %s%0d)",
             words_sent, atoms_sent, results_seen, status_tally[edp_pkg::ST_OK],
             status_tally[edp_pkg::ST_BAD], "overflow ", status_tally[edp_pkg::ST_OVER]);
    $display("Tags ran at reset, all-zero, all-ones and random values; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/edp_pkg.sv
rtl/core/edp_ram.sv
rtl/core/edp_loader.sv
rtl/core/edp_job_queue.sv
rtl/core/edp_parser.sv
rtl/core/es_descriptor_parser.sv
sim/tb_top.sv
